### sv/port_forwarding_decision_top_assert.svh
// Assertion macros for the port forwarding decision block.
// Included by the top level; no other dependencies.
`ifndef PORT_FORWARDING_DECISION_TOP_ASSERT_SVH
`define PORT_FORWARDING_DECISION_TOP_ASSERT_SVH

// same-cycle implication, checked outside reset
`define PFD_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("pfd assertion failed");

// next-cycle implication, checked outside reset
`define PFD_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("pfd assertion failed");

`endif

### sv/pfd_pkg.sv
// Shared types and constants for the port forwarding decision block.
// No dependencies.
package pfd_pkg;

    localparam int LOCAL_PORTS   = 4;
    localparam int ADDRESS_BYTES = 6;
    localparam int NUM_PORTS     = LOCAL_PORTS + 1;
    localparam int MAC_W         = 8 * ADDRESS_BYTES;
    localparam int PORT_W        = 3;
    localparam int CNT_W         = 32;
    localparam int APB_DATA_W    = 64;
    localparam int APB_ADDR_W    = 6;

    localparam logic [PORT_W-1:0] UPLINK_PORT = PORT_W'(LOCAL_PORTS);

    // register indexes (byte address = 8 * index)
    localparam logic [2:0] REG_MAC_ZERO     = 3'd0;
    localparam logic [2:0] REG_MAC_ONE      = 3'd1;
    localparam logic [2:0] REG_MAC_TWO      = 3'd2;
    localparam logic [2:0] REG_MAC_THREE    = 3'd3;
    localparam logic [2:0] REG_PRESENT_MASK = 3'd4;
    localparam logic [2:0] REG_REMOTE       = 3'd5;
    localparam logic [2:0] REG_POWER_MASK   = 3'd6;

    typedef enum logic [1:0] {
        VERDICT_FORWARD = 2'd0,
        VERDICT_DROP    = 2'd1,
        VERDICT_IGNORE  = 2'd2
    } t_verdict;

    typedef struct packed {
        logic [LOCAL_PORTS-1:0][MAC_W-1:0] local_mac;
        logic [LOCAL_PORTS-1:0]            present_mask;
        logic                              remote_present;
        logic [NUM_PORTS-1:0]              power_mask;
    } t_cfg;

    typedef struct packed {
        logic [NUM_PORTS-1:0] egress_mask;
        t_verdict             verdict;
        logic                 counted;    // source accepted, counters update
        logic [CNT_W-1:0]     in_total;
        logic [CNT_W-1:0]     drop_total;
    } t_decision;

endpackage

### sv/pfd_in_if.sv
// Header input channel: valid/ready plus one packet header.
// Depends on pfd_pkg.
interface pfd_in_if import pfd_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [PORT_W-1:0]    source_port;
    logic [MAC_W-1:0]     dest_mac;
    logic [NUM_PORTS-1:0] link_mask;

    modport source (output valid, source_port, dest_mac, link_mask, input ready);
    modport sink   (input valid, source_port, dest_mac, link_mask, output ready);
endinterface

### sv/pfd_out_if.sv
// Decision output channel: valid/ready plus one forwarding result.
// Depends on pfd_pkg.
interface pfd_out_if import pfd_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [NUM_PORTS-1:0] egress_mask;
    logic [1:0]           verdict;
    logic [CNT_W-1:0]     source_in_total;
    logic [CNT_W-1:0]     source_drop_total;

    modport source (output valid, egress_mask, verdict, source_in_total, source_drop_total,
                    input ready);
    modport sink   (input valid, egress_mask, verdict, source_in_total, source_drop_total,
                    output ready);
endinterface

### sv/pfd_cfg_regs.sv
// APB configuration registers: local MACs, present bits, power mask.
// Depends on pfd_pkg.
module pfd_cfg_regs import pfd_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output t_cfg                  o_cfg
);

    t_cfg       r_cfg;
    logic       wr_en;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[APB_ADDR_W-1:3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (wr_en) begin
            case (reg_idx)
                REG_MAC_ZERO:     r_cfg.local_mac[0]   <= pwdata[MAC_W-1:0];
                REG_MAC_ONE:      r_cfg.local_mac[1]   <= pwdata[MAC_W-1:0];
                REG_MAC_TWO:      r_cfg.local_mac[2]   <= pwdata[MAC_W-1:0];
                REG_MAC_THREE:    r_cfg.local_mac[3]   <= pwdata[MAC_W-1:0];
                REG_PRESENT_MASK: r_cfg.present_mask   <= pwdata[LOCAL_PORTS-1:0];
                REG_REMOTE:       r_cfg.remote_present <= pwdata[0];
                REG_POWER_MASK:   r_cfg.power_mask     <= pwdata[NUM_PORTS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_MAC_ZERO:     prdata = APB_DATA_W'(r_cfg.local_mac[0]);
            REG_MAC_ONE:      prdata = APB_DATA_W'(r_cfg.local_mac[1]);
            REG_MAC_TWO:      prdata = APB_DATA_W'(r_cfg.local_mac[2]);
            REG_MAC_THREE:    prdata = APB_DATA_W'(r_cfg.local_mac[3]);
            REG_PRESENT_MASK: prdata = APB_DATA_W'(r_cfg.present_mask);
            REG_REMOTE:       prdata = APB_DATA_W'(r_cfg.remote_present);
            REG_POWER_MASK:   prdata = APB_DATA_W'(r_cfg.power_mask);
            default:          prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

### sv/pfd_counters.sv
// Per-port received and dropped packet counters with a single write port.
// Depends on pfd_pkg.
module pfd_counters import pfd_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [PORT_W-1:0] i_port,
    input  logic              i_wr_en,
    input  logic [CNT_W-1:0]  i_in_total,
    input  logic [CNT_W-1:0]  i_drop_total,
    output logic [CNT_W-1:0]  o_in_count,
    output logic [CNT_W-1:0]  o_drop_count
);

    logic [CNT_W-1:0] r_in_cnt   [NUM_PORTS];
    logic [CNT_W-1:0] r_drop_cnt [NUM_PORTS];
    logic             port_ok;

    // ports past the remote one have no counters
    assign port_ok = (i_port <= UPLINK_PORT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_PORTS; i++) begin
                r_in_cnt[i]   <= '0;
                r_drop_cnt[i] <= '0;
            end
        end else if (i_wr_en && port_ok) begin
            r_in_cnt[i_port]   <= i_in_total;
            r_drop_cnt[i_port] <= i_drop_total;
        end
    end

    assign o_in_count   = port_ok ? r_in_cnt[i_port]   : '0;
    assign o_drop_count = port_ok ? r_drop_cnt[i_port] : '0;

endmodule

### sv/pfd_decide.sv
// Forwarding decision for one header: ignore, flood, unicast match, fallback, drop.
// Depends on pfd_pkg.
module pfd_decide import pfd_pkg::*; (
    input  t_cfg                 i_cfg,
    input  logic [PORT_W-1:0]    i_source_port,
    input  logic [MAC_W-1:0]     i_dest_mac,
    input  logic [NUM_PORTS-1:0] i_link_mask,
    input  logic [CNT_W-1:0]     i_in_count,
    input  logic [CNT_W-1:0]     i_drop_count,
    output t_decision            o_dec
);

    logic                   src_in_range;
    logic                   src_local;
    logic                   src_exists;
    logic                   src_active;
    logic                   is_flood;
    logic [NUM_PORTS-1:0]   linked;
    logic [NUM_PORTS-1:0]   src_onehot;
    logic [LOCAL_PORTS-1:0] cand;
    logic [NUM_PORTS-1:0]   target;
    logic [NUM_PORTS-1:0]   flood_mask;
    logic                   drop;

    assign src_in_range = (i_source_port <= UPLINK_PORT);
    assign src_local    = (i_source_port < UPLINK_PORT);
    assign src_onehot   = src_in_range ? NUM_PORTS'(1) << i_source_port : '0;
    assign src_exists   = src_local ? |(i_cfg.present_mask & src_onehot[LOCAL_PORTS-1:0])
                                    : i_cfg.remote_present;
    assign src_active   = src_in_range && src_exists && |(i_cfg.power_mask & src_onehot);

    assign is_flood = &i_dest_mac;
    assign linked   = i_link_mask & i_cfg.power_mask;

    assign flood_mask = {src_local && i_cfg.remote_present && linked[NUM_PORTS-1],
                         i_cfg.present_mask & linked[LOCAL_PORTS-1:0]
                                            & ~src_onehot[LOCAL_PORTS-1:0]};

    always_comb begin
        for (int p = 0; p < LOCAL_PORTS; p++) begin
            cand[p] = i_cfg.present_mask[p] && i_cfg.power_mask[p] &&
                      (i_cfg.local_mac[p] == i_dest_mac);
        end
    end

    // first matching local port wins; remote is the fallback for local sources
    always_comb begin
        target = '0;
        for (int p = LOCAL_PORTS - 1; p >= 0; p--) begin
            if (cand[p]) begin
                target = NUM_PORTS'(1) << p;
            end
        end
        if (!(|cand) && src_local && i_cfg.remote_present) begin
            target = NUM_PORTS'(1) << UPLINK_PORT;
        end
    end

    assign drop = !is_flood && !(|(target & linked));

    always_comb begin
        o_dec.counted     = src_active;
        o_dec.egress_mask = '0;
        o_dec.verdict     = VERDICT_IGNORE;
        o_dec.in_total    = i_in_count;
        o_dec.drop_total  = i_drop_count;
        if (src_active) begin
            o_dec.in_total = i_in_count + CNT_W'(1);
            if (is_flood) begin
                o_dec.verdict     = VERDICT_FORWARD;
                o_dec.egress_mask = flood_mask;
            end else if (drop) begin
                o_dec.verdict    = VERDICT_DROP;
                o_dec.drop_total = i_drop_count + CNT_W'(1);
            end else begin
                o_dec.verdict     = VERDICT_FORWARD;
                o_dec.egress_mask = target;
            end
        end
    end

endmodule

### sv/port_forwarding_decision_top.sv
// Port forwarding decision block for a four-port switch with one remote uplink.
//
// Channels: i_in carries one packet header per transfer (source port,
// destination MAC, far-end link mask); o_out carries one decision per header
// (egress mask, verdict, updated received/dropped totals of the source port).
// The APB port writes and reads the local MACs, present bits and power mask;
// change them only while no header is in flight.
// Path: a taken header sits in the input register, the decision is computed
// in one pass and registered in the output register, visible on o_out from
// then on. Throughput: one header per cycle while o_out does not stall, set by
// the single counter read-modify-write per pass, done before the next header.
// Reset (synchronous, active low) clears both stages, all configuration
// registers and all per-port counters.
// When o_out stalls, the finished decision holds in the output register and
// one more header is taken into the input register; then i_in.ready drops
// until the receiver takes the pending transfer.
module port_forwarding_decision_top import pfd_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    pfd_in_if.sink                i_in,
    pfd_out_if.source             o_out,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    `include "port_forwarding_decision_top_assert.svh"

    t_cfg      cfg;
    t_decision dec;

    logic                 r_in_valid;
    logic [PORT_W-1:0]    r_in_src;
    logic [MAC_W-1:0]     r_in_mac;
    logic [NUM_PORTS-1:0] r_in_link;

    logic                 r_out_valid;
    logic [NUM_PORTS-1:0] r_out_egress;
    t_verdict             r_out_verdict;
    logic [CNT_W-1:0]     r_out_in_total;
    logic [CNT_W-1:0]     r_out_drop_total;

    logic [CNT_W-1:0] in_count;
    logic [CNT_W-1:0] drop_count;
    logic             advance;
    logic             in_xfer;

    pfd_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    pfd_counters u_cnt (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_port       (r_in_src),
        .i_wr_en      (advance && dec.counted),
        .i_in_total   (dec.in_total),
        .i_drop_total (dec.drop_total),
        .o_in_count   (in_count),
        .o_drop_count (drop_count)
    );

    pfd_decide u_dec (
        .i_cfg         (cfg),
        .i_source_port (r_in_src),
        .i_dest_mac    (r_in_mac),
        .i_link_mask   (r_in_link),
        .i_in_count    (in_count),
        .i_drop_count  (drop_count),
        .o_dec         (dec)
    );

    // decision moves to the output register when that slot is free or draining
    assign advance    = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || advance;
    assign in_xfer    = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_xfer) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in_src  <= i_in.source_port;
            r_in_mac  <= i_in.dest_mac;
            r_in_link <= i_in.link_mask;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_egress     <= dec.egress_mask;
            r_out_verdict    <= dec.verdict;
            r_out_in_total   <= dec.in_total;
            r_out_drop_total <= dec.drop_total;
        end
    end

    assign o_out.valid             = r_out_valid;
    assign o_out.egress_mask       = r_out_egress;
    assign o_out.verdict           = r_out_verdict;
    assign o_out.source_in_total   = r_out_in_total;
    assign o_out.source_drop_total = r_out_drop_total;

    `PFD_ASSERT_IMP(a_no_egress_unless_fwd, i_clk, i_rst_n,
        r_out_valid && (r_out_verdict != VERDICT_FORWARD), r_out_egress == '0)
    `PFD_ASSERT_IMP(a_full_stall_blocks_in, i_clk, i_rst_n,
        r_in_valid && r_out_valid && !o_out.ready, !i_in.ready)
    `PFD_ASSERT_NEXT(a_drop_counts_one_more, i_clk, i_rst_n,
        advance && (dec.verdict == VERDICT_DROP),
        r_out_drop_total == $past(drop_count) + CNT_W'(1))

endmodule
